// ===== hw/rtl/skvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Shared sizes, transaction types and status codes for the sorted table.
// ----------------------------------------------------------------------------
package skvt_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int KEY_W       = 16;
	localparam int VAL_W       = 16;
	localparam int PAIR_W      = KEY_W + VAL_W;

	localparam logic       MODE_GET = 1'b0;
	localparam logic       MODE_SET = 1'b1;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_ABSENT   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_KEY_ZERO = 2'd3;

	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic [1:0]       status;
	} rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/skvt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted table storage
// Simple dual-address RAM: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module skvt_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_key_value_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key/value table
// Binary-search map of 16-bit keys to 16-bit values with sorted insertion.
// ----------------------------------------------------------------------------
// The table holds up to MAX_ENTRIES key/value pairs in ascending key order in
// a single RAM with one write and one registered read port. A get transaction
// returns the stored value (status 0) or zero with status 1 when the key is
// absent. A set transaction overwrites the value of a present key (status 0),
// or inserts the pair at its sorted place (status 1), or is dropped with
// status 2 when the table is full. Key zero is answered at once with status 3
// and changes nothing. One transaction is worked on at a time and the request
// side is stalled meanwhile. The RAM read port sets the pace: each binary
// search step issues a probe read, then compares the registered read data,
// and an insert then moves every later entry up by one slot, reading each
// entry and writing it back one slot higher. A finished result waits in an
// output register, so the next request is taken while it is still stalled.
// ----------------------------------------------------------------------------
module sorted_key_value_table
	import skvt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// Sequencer state codes.
	localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
	localparam logic [2:0] S_SRCH = 3'd1;  // issue the probe read or finish search
	localparam logic [2:0] S_CMP  = 3'd2;  // narrow the search window
	localparam logic [2:0] S_CHK  = 3'd3;  // test the lower-bound entry for a hit
	localparam logic [2:0] S_SHR  = 3'd4;  // read the entry below the hole
	localparam logic [2:0] S_SHW  = 3'd5;  // move that entry up one slot
	localparam logic [2:0] S_DONE = 3'd6;  // hand the result to the output register

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [IDX_W-1:0] mid_q;
	logic [CNT_W-1:0] shift_q;
	logic             mode_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] rv_q;
	logic [1:0]       st_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic              req_fire;
	logic              out_free;
	logic [CNT_W:0]    mid_sum;
	logic [IDX_W-1:0]  mid;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [PAIR_W-1:0] wdata;
	logic [IDX_W-1:0]  raddr;
	logic [PAIR_W-1:0] rdata;
	logic [KEY_W-1:0]  rkey;
	logic [VAL_W-1:0]  rval;
	logic              hit;
	logic [CNT_W-1:0]  shift_dec;

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Midpoint of the current search window; while the window is not empty it is below the count.
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[IDX_W:1];

	assign rkey      = rdata[PAIR_W-1:VAL_W];
	assign rval      = rdata[VAL_W-1:0];
	assign hit       = (lo_q < count_q) && (rkey == key_q);
	assign shift_dec = shift_q - CNT_W'(1);

	// RAM port control. Reads are issued in the cycle before their data is used.
	always_comb begin
		we    = 1'b0;
		waddr = lo_q[IDX_W-1:0];
		wdata = {key_q, value_q};
		raddr = lo_q[IDX_W-1:0];
		case (state_q)
			S_SRCH: begin
				if (lo_q < hi_q) begin
					raddr = mid;
				end
			end
			S_CHK: begin
				// A set on a present key overwrites its value in place.
				we = (mode_q == MODE_SET) && hit;
			end
			S_SHR: begin
				if (shift_q > lo_q) begin
					raddr = shift_dec[IDX_W-1:0];
				end else begin
					we = 1'b1;
				end
			end
			S_SHW: begin
				we    = 1'b1;
				waddr = shift_q[IDX_W-1:0];
				wdata = rdata;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	skvt_ram #(
		.DEPTH(MAX_ENTRIES),
		.WIDTH(PAIR_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Request payload and working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					mode_q  <= req.mode;
					key_q   <= req.key;
					value_q <= req.value;
					lo_q    <= '0;
					hi_q    <= count_q;
					rv_q    <= '0;
					st_q    <= ST_KEY_ZERO;
				end
			end
			S_SRCH: begin
				mid_q <= mid;
			end
			S_CMP: begin
				if (rkey < key_q) begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end else begin
					hi_q <= CNT_W'(mid_q);
				end
			end
			S_CHK: begin
				shift_q <= count_q;
				if (mode_q == MODE_GET) begin
					rv_q <= hit ? rval : '0;
					st_q <= hit ? ST_FOUND : ST_ABSENT;
				end else if (hit) begin
					st_q <= ST_FOUND;
				end else if (count_q == CNT_W'(MAX_ENTRIES)) begin
					st_q <= ST_FULL;
				end else begin
					st_q <= ST_ABSENT;
				end
			end
			S_SHW: begin
				shift_q <= shift_dec;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, entry count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= (req.key == '0) ? S_DONE : S_SRCH;
					end
				end
				S_SRCH: begin
					state_q <= (lo_q < hi_q) ? S_CMP : S_CHK;
				end
				S_CMP: begin
					state_q <= S_SRCH;
				end
				S_CHK: begin
					if ((mode_q == MODE_SET) && !hit
						&& (count_q != CNT_W'(MAX_ENTRIES))) begin
						state_q <= S_SHR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHR: begin
					if (shift_q > lo_q) begin
						state_q <= S_SHW;
					end else begin
						// The new pair has been written into the hole.
						count_q <= count_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_SHW: begin
					state_q <= S_SHR;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_q.read_value <= rv_q;
			out_q.status     <= st_q;
		end
	end

endmodule
`default_nettype wire

// ===== verif/skvt_table_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table checker
// Watches both channels, keeps a shadow table and compares every answer.
// ----------------------------------------------------------------------------
module skvt_table_checker
	import skvt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_stall,
	input  wire req_t req,
	input  wire logic rsp_valid,
	input  wire logic rsp_stall,
	input  wire rsp_t rsp,
	output int        fail_count,
	output int        pending,
	output int        peak_fill,
	output int        found_count,
	output int        absent_count,
	output int        full_count,
	output int        zero_count
);

	// Shadow copy of the table. Only slots below shadow_fill hold live pairs.
	logic [KEY_W-1:0] shadow_keys [MAX_ENTRIES];
	logic [VAL_W-1:0] shadow_vals [MAX_ENTRIES];
	int               shadow_fill;

	rsp_t             awaited_answers [$];

	// Applies one request to the shadow table and returns the answer it earns.
	function automatic rsp_t apply_to_shadow_table(input req_t r);
		rsp_t answer;
		int   lo;
		int   hi;
		int   mid;
		int   i;
		logic hit;
		answer.read_value = '0;
		answer.status     = ST_FOUND;
		if (r.key == '0) begin
			answer.status = ST_KEY_ZERO;
			return answer;
		end
		// Lower bound: first slot whose key is not below the request key.
		lo = 0;
		hi = shadow_fill;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (shadow_keys[mid] < r.key)
				lo = mid + 1;
			else
				hi = mid;
		end
		hit = (lo < shadow_fill) && (shadow_keys[lo] == r.key);
		if (r.mode == MODE_GET) begin
			if (hit)
				answer.read_value = shadow_vals[lo];
			else
				answer.status = ST_ABSENT;
		end else if (hit) begin
			shadow_vals[lo] = r.value;
		end else if (shadow_fill >= MAX_ENTRIES) begin
			answer.status = ST_FULL;
		end else begin
			for (i = shadow_fill; i > lo; i--) begin
				shadow_keys[i] = shadow_keys[i-1];
				shadow_vals[i] = shadow_vals[i-1];
			end
			shadow_keys[lo] = r.key;
			shadow_vals[lo] = r.value;
			shadow_fill++;
			answer.status = ST_ABSENT;
		end
		return answer;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t awaited;
		if (!arst_n) begin
			shadow_fill = 0;
			awaited_answers.delete();
			pending = 0;
		end else begin
			if (req_valid && !req_stall)
				awaited_answers.push_back(apply_to_shadow_table(req));
			if (rsp_valid && !rsp_stall) begin
				if (awaited_answers.size() == 0) begin
					$display("%0t: answer with none outstanding: read_value %h status %0d",
						$time, rsp.read_value, rsp.status);
					fail_count++;
				end else begin
					awaited = awaited_answers.pop_front();
					if (rsp.read_value !== awaited.read_value) begin
						$display("%0t: read_value mismatch: expected %h, actual %h",
							$time, awaited.read_value, rsp.read_value);
						fail_count++;
					end
					if (rsp.status !== awaited.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, awaited.status, rsp.status);
						fail_count++;
					end
					case (awaited.status)
						ST_FOUND:  found_count++;
						ST_ABSENT: absent_count++;
						ST_FULL:   full_count++;
						default:   zero_count++;
					endcase
				end
			end
			pending = awaited_answers.size();
			if (shadow_fill > peak_fill)
				peak_fill = shadow_fill;
		end
	end

endmodule

// ===== verif/tb_sorted_key_value_table.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table testbench
// Drives directed and random get/set traffic with random idling on both sides
// and leaves answer checking to the table checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_sorted_key_value_table;
	import skvt_pkg::*;

	// The random part is sized to fill the table about halfway through, so
	// the second half runs against a full table with drops and in-place
	// updates.
	localparam int RANDOM_ITEMS = 1460;
	// The slowest transaction is an insert at the front of a nearly full table:
	// a full search plus a read and a write per moved entry. The limit
	// takes that for every item, with stalls, several times over.
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int DRAIN_CYCLES = 1000;
	localparam int IDLE_PERCENT = 27;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int fail_count;
	int pending;
	int peak_fill;
	int found_count;
	int absent_count;
	int full_count;
	int zero_count;

	// While steady is high neither side idles, which gives one long stretch
	// of back-to-back traffic.
	bit steady = 1'b0;
	int sent_count = 0;
	int cycle_count = 0;

	// Keys that have been sent with a set, so gets and updates can aim at
	// keys that are likely stored.
	logic [KEY_W-1:0] known_keys [$];

	sorted_key_value_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	skvt_table_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.pending      (pending),
		.peak_fill    (peak_fill),
		.found_count  (found_count),
		.absent_count (absent_count),
		.full_count   (full_count),
		.zero_count   (zero_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// The response side stalls at random, changing only at the falling edge.
	always @(negedge clk) begin
		rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d answers outstanding.",
				cycle_count, pending);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic req_t make_req(input logic mode, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] value);
		req_t r;
		r.mode  = mode;
		r.key   = key;
		r.value = value;
		return r;
	endfunction

	// Values lean toward the extremes now and then.
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] pick_known_key();
		return known_keys[$urandom_range(0, known_keys.size() - 1)];
	endfunction

	// A key meant to be new: mostly random, sometimes at the ends of the key
	// range or right next to a stored key, where the search bounds are tight.
	function automatic logic [KEY_W-1:0] pick_fresh_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(0, 9))
			0:       k = KEY_W'($urandom_range(1, 3));
			1:       k = KEY_W'($urandom_range(16'hFFFC, 16'hFFFF));
			2, 3: begin
				if (known_keys.size() == 0)
					k = KEY_W'($urandom);
				else if ($urandom_range(0, 1) == 1)
					k = pick_known_key() + 16'd1;
				else
					k = pick_known_key() - 16'd1;
			end
			default: k = KEY_W'($urandom);
		endcase
		if (k == '0)
			k = 16'd1;
		return k;
	endfunction

	// Presents one transaction from the falling edge on and returns just after
	// the rising edge that accepted it. Idle cycles come first, at random.
	task automatic offer_request(input req_t item);
		@(negedge clk);
		while (!steady && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		if (item.mode == MODE_SET && item.key != '0)
			known_keys.push_back(item.key);
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent_count++;
	endtask

	initial begin
		req_t item;
		int   choice;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. The table starts empty, so the first get must miss.
		offer_request(make_req(MODE_GET, 16'h0005, 16'h0000));
		// Key zero is answered at once for both modes and never stored.
		offer_request(make_req(MODE_GET, 16'h0000, 16'hFFFF));
		offer_request(make_req(MODE_SET, 16'h0000, 16'hFFFF));
		offer_request(make_req(MODE_GET, 16'h0000, 16'h0000));
		// Inserts at the top end, the bottom end and in the middle.
		offer_request(make_req(MODE_SET, 16'hFFFF, 16'hFFFF));
		offer_request(make_req(MODE_SET, 16'h0001, 16'h0000));
		offer_request(make_req(MODE_SET, 16'h8000, 16'h1234));
		offer_request(make_req(MODE_SET, 16'h7FFF, 16'hA5A5));
		offer_request(make_req(MODE_SET, 16'hFFFE, 16'h5555));
		// Hits at both ends and in the middle, misses between stored keys.
		offer_request(make_req(MODE_GET, 16'hFFFF, 16'h0000));
		offer_request(make_req(MODE_GET, 16'h0001, 16'hFFFF));
		offer_request(make_req(MODE_GET, 16'h7FFF, 16'h0000));
		offer_request(make_req(MODE_GET, 16'h8001, 16'h0000));
		offer_request(make_req(MODE_GET, 16'h0002, 16'h0000));
		// Updating with the same value still counts as an in-place update.
		offer_request(make_req(MODE_SET, 16'h8000, 16'h1234));
		offer_request(make_req(MODE_SET, 16'h8000, 16'hFFFF));
		offer_request(make_req(MODE_GET, 16'h8000, 16'h0000));
		offer_request(make_req(MODE_GET, 16'hFFFE, 16'hFFFF));

		// Random part. Roughly a third of the transactions insert new keys, so
		// the table fills part way through; after that new keys are dropped
		// while updates and lookups of stored keys keep going.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 500) && (n < 800);
			choice = $urandom_range(0, 99);
			if (choice < 5) begin
				item = make_req(1'($urandom_range(0, 1)), '0, pick_value());
				offer_request(item);
			end else if (choice < 40 || known_keys.size() == 0) begin
				offer_request(make_req(MODE_SET, pick_fresh_key(), pick_value()));
			end else if (choice < 55) begin
				offer_request(make_req(MODE_SET, pick_known_key(), pick_value()));
			end else if (choice < 60) begin
				// The same set twice: the second one rewrites an unchanged value.
				item = make_req(MODE_SET, pick_known_key(), pick_value());
				offer_request(item);
				offer_request(item);
			end else if (choice < 85) begin
				offer_request(make_req(MODE_GET, pick_known_key(), pick_value()));
			end else begin
				offer_request(make_req(MODE_GET, pick_fresh_key(), pick_value()));
			end
		end
		steady = 1'b0;
		@(negedge clk);
		req_valid <= 1'b0;

		// Let every answer come back, then give the block time to show any
		// answer that should not be there.
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d get/set transactions; the table peaked at %0d of %0d entries.",
			sent_count, peak_fill, MAX_ENTRIES);
		$display("Answers: %0d found or updated, %0d absent or inserted,",
			found_count, absent_count);
		$display("         %0d dropped full, %0d key zero.",
			full_count, zero_count);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
